@@ rtl/core/bht_pkg.sv @@
package bht_pkg;

  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned BUCKET_W  = 8;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned DIN_W     = 32;
  localparam int unsigned COUNT_W   = 11;
  localparam logic [7:0]  HASH_SEED = 8'hFF;
  localparam int unsigned KEY_BYTES = 8;

  typedef enum logic [2:0] {
    FUNC_SET     = 3'd0,
    FUNC_TRY_SET = 3'd1,
    FUNC_GET     = 3'd2,
    FUNC_UNSET   = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [KEY_W-1:0] key;
    logic [DIN_W-1:0] data_in;
    logic             write_data;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic               success;
    logic [DIN_W-1:0]   data_out;
    logic [COUNT_W-1:0] entry_count;
  } out_word_t;

  // xor of the seed and every key byte rotated right by its byte index
  function automatic logic [BUCKET_W-1:0] bucket_of(logic [KEY_W-1:0] key);
    logic [7:0]  h;
    logic [15:0] dbl;
    h = HASH_SEED;
    for (int i = 0; i < KEY_BYTES; i++) begin
      dbl = {key[8*i +: 8], key[8*i +: 8]} >> i;
      h   = h ^ dbl[7:0];
    end
    return h;
  endfunction

endpackage

@@ rtl/core/bucketed_hash_table_unit.sv @@
// a new word is accepted only in idle, so each word is finished before the next is taken;
// the write state stalls while a result waits to be taken; the shared key
// comparator checks one way of the bucket row per cycle, then one row write-back
// reset: control, entry count and per-bucket row-valid flops clear at once,
// so the store reads as empty straight after reset with no clearing pass
module bucketed_hash_table_unit
  import bht_pkg::*;
#(
  parameter int unsigned WAYS       = 4,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W = $clog2(BUCKETS * WAYS + 1);

  // bucket row memory
  logic [WAYS-1:0][KEY_W-1:0]      key_mem   [BUCKETS];
  logic [WAYS-1:0][DATA_WIDTH-1:0] data_mem  [BUCKETS];
  logic [WAYS-1:0]                 valid_mem [BUCKETS];

  logic [WAYS-1:0][KEY_W-1:0]      key_row_q,  key_row_d;
  logic [WAYS-1:0][DATA_WIDTH-1:0] data_row_q, data_row_d;
  logic [WAYS-1:0]                 valid_row_q, valid_row_d, valid_eff;

  logic [BUCKETS-1:0] row_ok_q, row_ok_d;

  state_e               state_q, state_d;
  in_word_t             in_q;
  logic [BUCKET_W-1:0]  bucket_q;
  logic [WAY_W-1:0]     way_q, way_d;
  logic                 found_q, found_d, free_q, free_d;
  logic [WAY_W-1:0]     found_way_q, found_way_d, free_way_q, free_way_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic                  in_fire, out_free, mem_we, way_valid, scan_last;
  logic [BUCKET_W-1:0]   in_bucket;
  logic [63:0]           din_ext, dout_ext;
  logic [DATA_WIDTH-1:0] din, dout;
  logic                  ok;
  logic [31:0]           cnt_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_bucket   = bucket_of(in_data_i.key);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign valid_eff = row_ok_q[bucket_q] ? valid_row_q : '0;
  assign way_valid = valid_eff[way_q];
  assign scan_last = (way_q == WAY_W'(WAYS - 1));
  assign din_ext   = {32'd0, in_q.data_in};
  assign din       = din_ext[DATA_WIDTH-1:0];

  // sequencer and scan
  always_comb begin
    state_d     = state_q;
    way_d       = way_q;
    found_d     = found_q;
    found_way_d = found_way_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
          way_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (way_valid) begin
          if (!found_q && (key_row_q[way_q] == in_q.key)) begin
            found_d     = 1'b1;
            found_way_d = way_q;
          end
        end else if (!free_q) begin
          free_d     = 1'b1;
          free_way_d = way_q;
        end
        if (scan_last) begin
          state_d = S_WRITE;
        end else begin
          way_d = way_q + 1'b1;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // operation and write-back
  always_comb begin
    key_row_d   = key_row_q;
    data_row_d  = data_row_q;
    valid_row_d = valid_eff;
    row_ok_d    = row_ok_q;
    total_d     = total_q;
    ok          = 1'b0;
    dout        = '0;
    mem_we      = 1'b0;
    case (in_q.func) inside
      FUNC_SET, FUNC_TRY_SET: begin
        if (found_q) begin
          if (in_q.func == FUNC_SET) begin
            ok = 1'b1;
            if (in_q.write_data) begin
              data_row_d[found_way_q] = din;
              mem_we = 1'b1;
            end
          end
          dout = data_row_d[found_way_q];
        end else if (free_q) begin
          valid_row_d[free_way_q] = 1'b1;
          key_row_d[free_way_q]   = in_q.key;
          data_row_d[free_way_q]  = in_q.write_data ? din : '0;
          total_d = total_q + 1'b1;
          ok      = 1'b1;
          mem_we  = 1'b1;
          dout    = data_row_d[free_way_q];
        end
      end
      FUNC_GET: begin
        if (found_q) begin
          ok   = 1'b1;
          dout = data_row_q[found_way_q];
        end
      end
      FUNC_UNSET: begin
        if (found_q) begin
          valid_row_d[found_way_q] = 1'b0;
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
          ok     = 1'b1;
          mem_we = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        row_ok_d = '0;
        total_d  = '0;
        ok       = 1'b1;
      end
      default: ;
    endcase
    if (mem_we) begin
      row_ok_d[bucket_q] = 1'b1;
    end
  end

  assign dout_ext = 64'(dout);
  assign cnt_ext  = 32'(total_d);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_WRITE) && out_free) begin
      out_valid_d       = 1'b1;
      out_d.hit         = found_q;
      out_d.success     = ok;
      out_d.data_out    = dout_ext[DIN_W-1:0];
      out_d.entry_count = cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      row_ok_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if ((state_q == S_WRITE) && out_free) begin
        total_q  <= total_d;
        row_ok_q <= row_ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    way_q       <= way_d;
    found_q     <= found_d;
    found_way_q <= found_way_d;
    free_q      <= free_d;
    free_way_q  <= free_way_d;
    out_q       <= out_d;
    if (in_fire) begin
      in_q     <= in_data_i;
      bucket_q <= in_bucket;
    end
  end

  // row read on accept, row write-back at the end of an operation that changes the row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_row_q   <= key_mem[in_bucket];
      data_row_q  <= data_mem[in_bucket];
      valid_row_q <= valid_mem[in_bucket];
    end
    if ((state_q == S_WRITE) && out_free && mem_we) begin
      key_mem[bucket_q]   <= key_row_d;
      data_mem[bucket_q]  <= data_row_d;
      valid_mem[bucket_q] <= valid_row_d;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bht_pkg::*;

  localparam int unsigned WAYS        = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned SLOTS       = BUCKETS * WAYS;
  localparam int unsigned POOL_BKTS   = 8;
  localparam int unsigned POOL_PER    = 6;
  localparam int unsigned N_RANDOM    = 1200;
  localparam int unsigned MAX_WAIT    = 17;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 4 * (WAYS + 2) + 20;
  localparam logic [2:0]  FUNC_RSVD_LO  = 3'd5;
  localparam logic [2:0]  FUNC_RSVD_MID = 3'd6;
  localparam logic [2:0]  FUNC_RSVD_HI  = 3'd7;

  typedef struct {
    in_word_t word;
    bit       drain;
  } table_op_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  out_word_t out_data_o;

  table_op_t   pending_ops[$];
  out_word_t   predicted_replies[$];
  int unsigned sent_cnt = 0;
  int unsigned got_cnt  = 0;
  int unsigned tx_wait  = 0;
  int unsigned rx_wait  = 0;
  int unsigned n_ops    = 0;
  int unsigned n_errors = 0;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key  [SLOTS];
  logic [DIN_W-1:0] shadow_data [SLOTS];
  bit               shadow_used [SLOTS];
  int unsigned      shadow_count = 0;

  logic [KEY_W-1:0] key_pool [POOL_BKTS*POOL_PER];

  bucketed_hash_table_unit #(
    .WAYS       (WAYS),
    .DATA_WIDTH (DATA_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] key_hash(input logic [KEY_W-1:0] key);
    logic [7:0] h;
    logic [7:0] b;
    logic [7:0] rot;
    h = HASH_SEED;
    for (int i = 0; i < 8; i++) begin
      b   = key[8*i +: 8];
      rot = (b >> i) | (b << (8 - i));
      h   = h ^ rot;
    end
    return h;
  endfunction

  // byte 0 enters the hash unrotated, so it can steer the key into any bucket
  function automatic logic [KEY_W-1:0] key_for_bucket(input logic [7:0] bkt);
    logic [KEY_W-1:0] key;
    key       = {$urandom, $urandom};
    key[7:0]  = 8'h00;
    key[7:0]  = bkt ^ key_hash(key);
    return key;
  endfunction

  function automatic out_word_t table_apply(input in_word_t w);
    out_word_t r;
    int        base;
    int        found;
    int        free_slot;
    base      = int'(key_hash(w.key)) * WAYS;
    found     = -1;
    free_slot = -1;
    r         = '0;
    for (int k = 0; k < WAYS; k++) begin
      if (shadow_used[base+k]) begin
        if (found < 0 && shadow_key[base+k] == w.key) found = base + k;
      end else if (free_slot < 0) begin
        free_slot = base + k;
      end
    end
    r.hit = (found >= 0);
    case (w.func) inside
      FUNC_SET, FUNC_TRY_SET: begin
        if (found >= 0) begin
          if (w.func == FUNC_SET) begin
            if (w.write_data) shadow_data[found] = w.data_in;
            r.success = 1'b1;
          end
          r.data_out = shadow_data[found];
        end else if (free_slot >= 0) begin
          shadow_used[free_slot] = 1'b1;
          shadow_key[free_slot]  = w.key;
          shadow_data[free_slot] = w.write_data ? w.data_in : '0;
          shadow_count++;
          r.success  = 1'b1;
          r.data_out = shadow_data[free_slot];
        end
      end
      FUNC_GET: begin
        if (found >= 0) begin
          r.success  = 1'b1;
          r.data_out = shadow_data[found];
        end
      end
      FUNC_UNSET: begin
        if (found >= 0) begin
          shadow_used[found] = 1'b0;
          if (shadow_count > 0) shadow_count--;
          r.success = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) shadow_used[s] = 1'b0;
        shadow_count = 0;
        r.success    = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void add_op(input logic [2:0] f, input logic [KEY_W-1:0] k,
                                 input logic [DIN_W-1:0] d, input logic wr,
                                 input bit drain = 1'b0);
    table_op_t op;
    op.word.func       = f;
    op.word.key        = k;
    op.word.data_in    = d;
    op.word.write_data = wr;
    op.drain           = drain;
    pending_ops.push_back(op);
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic        vld;
    int unsigned sent_now;
    table_op_t   op;
    vld      = in_valid;
    sent_now = sent_cnt;
    if (!rst_ni) begin
      vld = 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predicted_replies.push_back(table_apply(in_data));
        sent_now = sent_cnt + 1;
        sent_cnt <= sent_now;
        vld      = 1'b0;
        tx_wait  = ((sent_now / 128) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!vld) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_ops.size() > 0 &&
                     (!pending_ops[0].drain || got_cnt == sent_now)) begin
          op = pending_ops.pop_front();
          in_data <= op.word;
          vld = 1'b1;
        end
      end
    end
    in_valid <= vld;
  end

  // monitor
  always @(posedge clk_i) begin
    logic        rdy;
    int unsigned seen;
    out_word_t   want;
    rdy = out_ready;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        seen = got_cnt + 1;
        got_cnt <= seen;
        if (predicted_replies.size() == 0) begin
          $error("result word %h with nothing expected", out_data_o);
          n_errors++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data_o.hit !== want.hit) begin
            $error("hit: expected %0h, actual %0h", want.hit, out_data_o.hit);
            n_errors++;
          end
          if (out_data_o.success !== want.success) begin
            $error("success: expected %0h, actual %0h", want.success, out_data_o.success);
            n_errors++;
          end
          if (out_data_o.data_out !== want.data_out) begin
            $error("data_out: expected %0h, actual %0h", want.data_out, out_data_o.data_out);
            n_errors++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_data_o.entry_count);
            n_errors++;
          end
        end
        rx_wait = ((seen / 128) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
        // long back-pressure so the input side fills and stalls
        if (seen == HOLD_AT) rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
    end
    out_ready <= rdy;
  end

  initial begin
    logic [KEY_W-1:0] kb [5];
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_mid;
    logic [KEY_W-1:0] k;
    logic [7:0]       bkt;
    logic [2:0]       f;
    int unsigned      r;

    k_ones = '1;
    k_mid  = 64'h0123_4567_89AB_CDEF;
    bkt    = 8'($urandom_range(0, 255));
    for (int i = 0; i < 5; i++) kb[i] = key_for_bucket(bkt);

    // directed
    add_op(FUNC_GET,     '0,     '0,           1'b1);
    add_op(FUNC_SET,     '0,     '1,           1'b1);
    add_op(FUNC_SET,     k_ones, '0,           1'b1);
    add_op(FUNC_TRY_SET, '0,     32'h1234,     1'b1);
    add_op(FUNC_SET,     '0,     32'h5555,     1'b0);
    add_op(FUNC_GET,     '0,     '0,           1'b0);
    add_op(FUNC_SET,     k_mid,  32'hAAAA,     1'b0);
    add_op(FUNC_TRY_SET, ~k_mid, 32'hDEADBEEF, 1'b1);
    for (int i = 0; i < 5; i++) add_op(FUNC_SET, kb[i], $urandom, 1'b1);
    add_op(FUNC_TRY_SET, kb[4],  $urandom,     1'b1);
    add_op(FUNC_UNSET,   kb[1],  '0,           1'b0);
    add_op(FUNC_UNSET,   kb[1],  '0,           1'b0);
    add_op(FUNC_SET,     kb[4],  '1,           1'b1);
    add_op(FUNC_GET,     kb[4],  '0,           1'b0);
    add_op(FUNC_RSVD_LO, kb[0],  '1,           1'b1);
    add_op(FUNC_RSVD_HI, k_ones, '1,           1'b1);
    add_op(FUNC_RSVD_MID, k_mid, '0,           1'b0);
    add_op(FUNC_CLEAR,   kb[0],  '0,           1'b0);
    add_op(FUNC_GET,     kb[0],  '0,           1'b0);
    add_op(FUNC_UNSET,   k_ones, '0,           1'b0);
    add_op(FUNC_SET,     k_ones, '1,           1'b1);

    // random, mostly on a pool of keys crowded into a few buckets
    for (int b = 0; b < POOL_BKTS; b++) begin
      bkt = 8'($urandom_range(0, 255));
      for (int j = 0; j < POOL_PER; j++) key_pool[b*POOL_PER+j] = key_for_bucket(bkt);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        k = key_pool[$urandom_range(0, POOL_BKTS*POOL_PER-1)];
      end else if (r < 87) begin
        k = '0;
      end else if (r < 89) begin
        k = '1;
      end else begin
        k = {$urandom, $urandom};
      end
      r = $urandom_range(0, 99);
      if (r < 30)      f = FUNC_SET;
      else if (r < 45) f = FUNC_TRY_SET;
      else if (r < 70) f = FUNC_GET;
      else if (r < 90) f = FUNC_UNSET;
      else if (r < 92) f = FUNC_CLEAR;
      else             f = 3'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
      add_op(f, k, $urandom, 1'($urandom_range(0, 1)), (i % 150) == 0);
    end
    n_ops = pending_ops.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(sent_cnt == n_ops && got_cnt == n_ops)) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (predicted_replies.size() != 0) begin
      $error("%0d expected results never arrived", predicted_replies.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
